// ===== design/pscc_pkg.sv =====
// Package for the PID steering and speed controller: widths, constants,
// datapath select codes and the microcode program.
// No dependencies; used by the core and by its checker.
package pscc_pkg;

	localparam int ERR_W   = 32;
	localparam int DIFF_W  = 33;
	localparam int SUM_W   = 48;
	localparam int GAIN_W  = 24;
	localparam int STEER_W = 8;
	localparam int SPEED_W = 10;
	localparam int TOT_W   = 32;
	localparam int CFG_W   = 2;
	localparam int OUT_W   = 56;

	localparam int MA_W    = 34;
	localparam int MB_W    = 25;
	localparam int PROD_W  = 59;
	localparam int ACC_W   = 73;
	localparam int NUM_W   = 49;
	localparam int REM_W   = 48;
	localparam int RAW_W   = 24;
	localparam int QUO_W   = 8;
	localparam int CNT_W   = 3;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd734003;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd1048576;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd210;

	localparam logic [STEER_W-1:0] STEER_MIN = 8'd40;
	localparam logic [STEER_W-1:0] STEER_MAX = 8'd140;
	localparam logic [STEER_W-1:0] STEER_MID = 8'd90;
	localparam logic signed [SPEED_W-1:0] SPEED_LO = -10'sd500;
	localparam logic signed [SPEED_W-1:0] SPEED_HI = -10'sd50;
	localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sd50;
	localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sd500;
	localparam logic signed [40:0] SPEED_BASE_Q16 = 41'sd22937600;

	localparam logic [MB_W-1:0] C_SPEED_SLOPE = 25'd200;
	localparam logic [MB_W-1:0] C_STRAIGHT    = 25'd90;
	localparam logic [MB_W-1:0] C_STEER_SCALE = 25'd30000;

	typedef enum logic [CFG_W-1:0] {
		REG_PROP  = 2'd0,
		REG_DERIV = 2'd1,
		REG_INTEG = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_WAIT, S_MUL_KP, S_MUL_KD, S_MUL_KILO, S_MUL_KIHI, S_ACC_HI, S_TOT,
		S_MUL_MAG, S_RAW, S_MUL_RAW, S_MUL_TOT, S_NUM, S_SETUP, S_DIV, S_CLAMP,
		S_EMIT
	} step_t;

	typedef enum logic [2:0] {
		A_E, A_D, A_LO, A_HI, A_TOT, A_MAG, A_RAW
	} a_sel_t;

	typedef enum logic [2:0] {
		B_KP, B_KD, B_KI, B_SLOPE, B_STRAIGHT, B_SCALE
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD_HI
	} acc_op_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_TAKE, OP_TOT, OP_RAW, OP_NUM_LOAD, OP_NUM_SUB, OP_SETUP,
		OP_DIV, OP_CLAMP, OP_EMIT
	} alu_op_t;

	typedef enum logic [2:0] {
		C_NEXT, C_JUMP, C_WAIT_IN, C_WAIT_OUT, C_RESOLVED, C_LOOP
	} cond_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc;
		alu_op_t alu;
		cond_t   cond;
		step_t   target;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '{A_E, B_KP, ACC_NONE, OP_NOP, C_NEXT, S_WAIT};
		case (s)
			S_WAIT:     w = '{A_E,   B_KP,       ACC_NONE,   OP_TAKE,     C_WAIT_IN,  S_MUL_KP};
			S_MUL_KP:   w = '{A_E,   B_KP,       ACC_NONE,   OP_NOP,      C_NEXT,     S_WAIT};
			S_MUL_KD:   w = '{A_D,   B_KD,       ACC_LOAD,   OP_NOP,      C_NEXT,     S_WAIT};
			S_MUL_KILO: w = '{A_LO,  B_KI,       ACC_ADD,    OP_NOP,      C_NEXT,     S_WAIT};
			S_MUL_KIHI: w = '{A_HI,  B_KI,       ACC_ADD,    OP_NOP,      C_NEXT,     S_WAIT};
			S_ACC_HI:   w = '{A_E,   B_KP,       ACC_ADD_HI, OP_NOP,      C_NEXT,     S_WAIT};
			S_TOT:      w = '{A_E,   B_KP,       ACC_NONE,   OP_TOT,      C_NEXT,     S_WAIT};
			S_MUL_MAG:  w = '{A_MAG, B_SLOPE,    ACC_NONE,   OP_NOP,      C_NEXT,     S_WAIT};
			S_RAW:      w = '{A_E,   B_KP,       ACC_NONE,   OP_RAW,      C_NEXT,     S_WAIT};
			S_MUL_RAW:  w = '{A_RAW, B_STRAIGHT, ACC_NONE,   OP_NOP,      C_NEXT,     S_WAIT};
			S_MUL_TOT:  w = '{A_TOT, B_SCALE,    ACC_NONE,   OP_NUM_LOAD, C_NEXT,     S_WAIT};
			S_NUM:      w = '{A_E,   B_KP,       ACC_NONE,   OP_NUM_SUB,  C_NEXT,     S_WAIT};
			S_SETUP:    w = '{A_E,   B_KP,       ACC_NONE,   OP_SETUP,    C_RESOLVED, S_EMIT};
			S_DIV:      w = '{A_E,   B_KP,       ACC_NONE,   OP_DIV,      C_LOOP,     S_DIV};
			S_CLAMP:    w = '{A_E,   B_KP,       ACC_NONE,   OP_CLAMP,    C_NEXT,     S_WAIT};
			S_EMIT:     w = '{A_E,   B_KP,       ACC_NONE,   OP_EMIT,     C_WAIT_OUT, S_WAIT};
			default:    w = '{A_E,   B_KP,       ACC_NONE,   OP_NOP,      C_JUMP,     S_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== design/pid_steer_speed_controller_core.sv =====
// PID steering and speed controller core: microcoded sequencer over one
// shared 34x25 multiplier, a 73-bit accumulator and an 8-step divider.
// Depends on pscc_pkg.
// A new sample is taken only in the wait step, after the last result has
// gone to the output register, so items are not overlapped; the quotient
// loop is skipped when the steering saturates before it. The multiplier is
// used serially and the quotient loop gives one bit per cycle.
// Reset: arst_n clears the sequencer, the integral, the previous sample
// and the output valid, and loads the default gains.
module pid_steer_speed_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pscc_pkg::ERR_W-1:0]    s_axis_tdata,  // [31:0] track_error
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pscc_pkg::OUT_W-1:0]    m_axis_tdata,  // [7:0] steer_cmd,
	                                                     // [17:8] speed_cmd,
	                                                     // [49:18] pid_total
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pscc_pkg::CFG_W-1:0]    cfg_index,
	input  logic [pscc_pkg::GAIN_W-1:0]   cfg_data
);

	pscc_pkg::step_t  pc_q, pc_next;
	pscc_pkg::ucode_t uw;

	logic [pscc_pkg::GAIN_W-1:0] kp_q, kd_q, ki_q;
	logic                        seeded_q;
	logic signed [pscc_pkg::ERR_W-1:0]  e_q, last_q;
	logic signed [pscc_pkg::DIFF_W-1:0] d_q;
	logic signed [pscc_pkg::SUM_W-1:0]  sum_q;

	logic signed [pscc_pkg::MA_W-1:0]   mul_a;
	logic signed [pscc_pkg::MB_W-1:0]   mul_b;
	logic signed [pscc_pkg::PROD_W-1:0] prod_s1;
	logic signed [pscc_pkg::ACC_W-1:0]  acc_q;
	logic signed [pscc_pkg::TOT_W-1:0]  tot_q;
	logic signed [pscc_pkg::RAW_W-1:0]  raw_q;
	logic signed [pscc_pkg::NUM_W-1:0]  num_q;
	logic [pscc_pkg::REM_W-1:0]         rem_q, dvs_q;
	logic [pscc_pkg::QUO_W-1:0]         quo_q;
	logic [pscc_pkg::CNT_W-1:0]         cnt_q;
	logic [pscc_pkg::STEER_W-1:0]       steer_q;

	logic [pscc_pkg::STEER_W-1:0]       out_steer_q;
	logic [pscc_pkg::SPEED_W-1:0]       out_speed_q;
	logic [pscc_pkg::TOT_W-1:0]         out_total_q;
	logic                               out_valid_q;

	logic in_acc, out_free;
	logic signed [pscc_pkg::SUM_W:0]    sum_ext;
	logic [pscc_pkg::SUM_W-1:0]         sum_next;
	logic signed [pscc_pkg::DIFF_W-1:0] d_next;
	logic [pscc_pkg::TOT_W:0]           tot_ext, tot_neg, mag;
	logic                               tot_fits;
	logic signed [40:0]                 nval, nneg;
	logic [40:0]                        nabs;
	logic [pscc_pkg::RAW_W:0]           rq;
	logic [pscc_pkg::RAW_W-1:0]         raw_next;
	logic [pscc_pkg::NUM_W-1:0]         num_neg;
	logic [pscc_pkg::REM_W-1:0]         num_abs;
	logic [pscc_pkg::RAW_W-1:0]         raw_neg;
	logic [pscc_pkg::RAW_W-2:0]         raw_abs;
	logic                               raw_zero, num_zero, sign_diff, big, resolved;
	logic [pscc_pkg::STEER_W-1:0]       preset;
	logic                               div_ge;
	logic [8:0]                         spd_mag;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (uw.cond == pscc_pkg::C_WAIT_IN);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_total_q, out_speed_q, out_steer_q};
	assign cfg_ready     = 1'b1;

	always_comb begin
		uw = pscc_pkg::ucode_rom(pc_q);
	end

	always_comb begin
		pc_next = pc_q;
		case (uw.cond)
			pscc_pkg::C_NEXT:     pc_next = pscc_pkg::step_t'(pc_q + 4'd1);
			pscc_pkg::C_JUMP:     pc_next = uw.target;
			pscc_pkg::C_WAIT_IN:  pc_next = in_acc ? uw.target : pc_q;
			pscc_pkg::C_WAIT_OUT: pc_next = out_free ? uw.target : pc_q;
			pscc_pkg::C_RESOLVED: pc_next = resolved ? uw.target : pscc_pkg::step_t'(pc_q + 4'd1);
			pscc_pkg::C_LOOP:     pc_next = (cnt_q != '0) ? uw.target : pscc_pkg::step_t'(pc_q + 4'd1);
			default:              pc_next = pscc_pkg::S_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pscc_pkg::S_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= pscc_pkg::PROP_GAIN_RST;
			kd_q <= pscc_pkg::DERIV_GAIN_RST;
			ki_q <= pscc_pkg::INTEG_GAIN_RST;
		end else if (cfg_valid) begin
			case (pscc_pkg::reg_idx_t'(cfg_index))
				pscc_pkg::REG_PROP:  kp_q <= cfg_data;
				pscc_pkg::REG_DERIV: kd_q <= cfg_data;
				pscc_pkg::REG_INTEG: ki_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// integral and derivative of the incoming sample
	always_comb begin
		sum_ext = {sum_q[pscc_pkg::SUM_W-1], sum_q}
			+ {{(pscc_pkg::SUM_W-pscc_pkg::ERR_W+1){s_axis_tdata[pscc_pkg::ERR_W-1]}},
			   s_axis_tdata};
		if (sum_ext[pscc_pkg::SUM_W] != sum_ext[pscc_pkg::SUM_W-1]) begin
			sum_next = {sum_ext[pscc_pkg::SUM_W], {(pscc_pkg::SUM_W-1){!sum_ext[pscc_pkg::SUM_W]}}};
		end else begin
			sum_next = sum_ext[pscc_pkg::SUM_W-1:0];
		end
		d_next = seeded_q
			? ($signed({s_axis_tdata[pscc_pkg::ERR_W-1], s_axis_tdata})
			   - $signed({last_q[pscc_pkg::ERR_W-1], last_q}))
			: '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			last_q   <= '0;
			sum_q    <= '0;
		end else if (uw.alu == pscc_pkg::OP_TAKE && in_acc) begin
			seeded_q <= 1'b1;
			last_q   <= s_axis_tdata;
			sum_q    <= sum_next;
		end
	end

	always_comb begin
		tot_ext = {tot_q[pscc_pkg::TOT_W-1], tot_q};
		tot_neg = '0 - tot_ext;
		mag     = tot_q[pscc_pkg::TOT_W-1] ? tot_neg : tot_ext;
	end

	always_comb begin
		case (uw.a_sel)
			pscc_pkg::A_E:   mul_a = {{2{e_q[31]}}, e_q};
			pscc_pkg::A_D:   mul_a = {d_q[32], d_q};
			pscc_pkg::A_LO:  mul_a = {14'd0, sum_q[19:0]};
			pscc_pkg::A_HI:  mul_a = {{6{sum_q[47]}}, sum_q[47:20]};
			pscc_pkg::A_TOT: mul_a = {{2{tot_q[31]}}, tot_q};
			pscc_pkg::A_MAG: mul_a = {1'b0, mag};
			pscc_pkg::A_RAW: mul_a = {{10{raw_q[23]}}, raw_q};
			default:         mul_a = '0;
		endcase
		case (uw.b_sel)
			pscc_pkg::B_KP:       mul_b = {1'b0, kp_q};
			pscc_pkg::B_KD:       mul_b = {1'b0, kd_q};
			pscc_pkg::B_KI:       mul_b = {1'b0, ki_q};
			pscc_pkg::B_SLOPE:    mul_b = pscc_pkg::C_SPEED_SLOPE;
			pscc_pkg::B_STRAIGHT: mul_b = pscc_pkg::C_STRAIGHT;
			pscc_pkg::B_SCALE:    mul_b = pscc_pkg::C_STEER_SCALE;
			default:              mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (uw.acc)
			pscc_pkg::ACC_LOAD:   acc_q <= {{14{prod_s1[58]}}, prod_s1};
			pscc_pkg::ACC_ADD:    acc_q <= acc_q + {{14{prod_s1[58]}}, prod_s1};
			pscc_pkg::ACC_ADD_HI: acc_q <= acc_q + {prod_s1[52:0], 20'd0};
			default: ;
		endcase
	end

	// total saturation check, raw speed, steering quotient setup and speed clamp
	always_comb begin
		tot_fits = (&acc_q[72:51]) || !(|acc_q[72:51]);
		nval     = pscc_pkg::SPEED_BASE_Q16 - $signed({1'b0, prod_s1[39:0]});
		nneg     = 41'sd0 - nval;
		nabs     = nval[40] ? nneg : nval;
		rq       = nabs[40:16];
		raw_next = nval[40] ? (24'd0 - rq[23:0]) : rq[23:0];

		num_neg   = '0 - num_q;
		num_abs   = num_q[48] ? num_neg[47:0] : num_q[47:0];
		raw_neg   = '0 - raw_q;
		raw_abs   = raw_q[23] ? raw_neg[22:0] : raw_q[22:0];
		raw_zero  = (raw_q == '0);
		num_zero  = (num_q == '0);
		sign_diff = num_q[48] ^ raw_q[23];
		big       = (num_abs >= {1'b0, raw_abs, 24'd0});
		resolved  = raw_zero || num_zero || sign_diff || big;
		if (raw_zero) begin
			preset = (!tot_q[31] && tot_q != '0) ? pscc_pkg::STEER_MIN : pscc_pkg::STEER_MAX;
		end else if (num_zero || sign_diff) begin
			preset = pscc_pkg::STEER_MIN;
		end else begin
			preset = pscc_pkg::STEER_MAX;
		end
		div_ge = (rem_q >= dvs_q);

		if (raw_q < pscc_pkg::RAW_MIN) begin
			spd_mag = 9'(pscc_pkg::RAW_MIN);
		end else if (raw_q > pscc_pkg::RAW_MAX) begin
			spd_mag = 9'(pscc_pkg::RAW_MAX);
		end else begin
			spd_mag = raw_q[8:0];
		end
	end

	always_ff @(posedge clk) begin
		case (uw.alu)
			pscc_pkg::OP_TAKE: begin
				if (in_acc) begin
					e_q <= s_axis_tdata;
					d_q <= d_next;
				end
			end
			pscc_pkg::OP_TOT: begin
				if (tot_fits) begin
					tot_q <= acc_q[51:20];
				end else begin
					tot_q <= {acc_q[72], {31{!acc_q[72]}}};
				end
			end
			pscc_pkg::OP_RAW:      raw_q <= raw_next;
			pscc_pkg::OP_NUM_LOAD: num_q <= {prod_s1[32:0], 16'd0};
			pscc_pkg::OP_NUM_SUB:  num_q <= num_q - prod_s1[48:0];
			pscc_pkg::OP_SETUP: begin
				steer_q <= preset;
				rem_q   <= num_abs;
				dvs_q   <= {2'd0, raw_abs, 23'd0};
				quo_q   <= '0;
				cnt_q   <= '1;
			end
			pscc_pkg::OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q <= {quo_q[6:0], div_ge};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - 3'd1;
			end
			pscc_pkg::OP_CLAMP: begin
				if (quo_q < pscc_pkg::STEER_MIN) begin
					steer_q <= pscc_pkg::STEER_MIN;
				end else if (quo_q > pscc_pkg::STEER_MAX) begin
					steer_q <= pscc_pkg::STEER_MAX;
				end else begin
					steer_q <= quo_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.alu == pscc_pkg::OP_EMIT && out_free) begin
			out_steer_q <= steer_q;
			out_speed_q <= 10'd0 - {1'b0, spd_mag};
			out_total_q <= tot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.alu == pscc_pkg::OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/pscc_checker.sv =====
// Port-level checker for the PID steering and speed controller core,
// bound to the core module. Depends on pscc_pkg.
module pscc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [pscc_pkg::OUT_W-1:0] m_axis_tdata
);

	logic [pscc_pkg::STEER_W-1:0]        steer;
	logic signed [pscc_pkg::SPEED_W-1:0] speed;
	logic signed [pscc_pkg::TOT_W-1:0]   total;

	assign steer = m_axis_tdata[7:0];
	assign speed = m_axis_tdata[17:8];
	assign total = m_axis_tdata[49:18];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> steer >= pscc_pkg::STEER_MIN && steer <= pscc_pkg::STEER_MAX)
		else $error("steer_cmd out of range");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> speed >= pscc_pkg::SPEED_LO && speed <= pscc_pkg::SPEED_HI)
		else $error("speed_cmd out of range");

	a_steer_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && total > 0 && speed != pscc_pkg::SPEED_HI
		|-> steer <= pscc_pkg::STEER_MID)
		else $error("steer_cmd on the wrong side for positive error");

endmodule

bind pid_steer_speed_controller_core pscc_checker u_pscc_checker (.*);
